/* rtl/core/nmea_pkg.sv */
// types, constants and helper functions for the nmea sentence frame parser
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package nmea_pkg;

	localparam int FIELD_LIMIT      = 32;
	localparam int MAX_SENTENCE_LEN = 128;
	localparam int FIELD_CAP        = (FIELD_LIMIT < 32) ? FIELD_LIMIT : 32;
	localparam int TABLE_DEPTH      = 32;
	localparam int QUEUE_DEPTH      = 2;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_F = 8'h66;

	typedef enum logic [2:0] {
		ERR_OK      = 3'd0,
		ERR_SHORT   = 3'd1,
		ERR_LEAD    = 3'd2,
		ERR_NO_STAR = 3'd3,
		ERR_DIGITS  = 3'd4,
		ERR_HEX     = 3'd5,
		ERR_MISMATCH = 3'd6,
		ERR_LONG    = 3'd7
	} err_code_t;

	// what the back end does with one byte
	typedef enum logic [2:0] {
		K_NONE     = 3'd0,
		K_LEAD     = 3'd1,
		K_STAR     = 3'd2,
		K_DATA     = 3'd3,
		K_DIGIT_HI = 3'd4,
		K_DIGIT_LO = 3'd5
	} byte_kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} in_item_t;

	typedef struct packed {
		logic        is_status;
		logic [4:0]  field_index;
		logic [6:0]  field_start;
		logic [6:0]  field_length;
		logic [2:0]  error_code;
		logic [5:0]  field_total;
		logic [15:0] talker_chars;
		logic [23:0] type_chars;
		logic        last_result;
	} out_item_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] pos;
		byte_kind_t kind;
		logic       last;
		logic       star_found;
		logic [7:0] star_pos;
	} q_entry_t;

	// bit 4 set marks a character that is no hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = 8'd0;
			if (c >= CH_ZERO && c <= CH_NINE) begin
				d = c - CH_ZERO;
				hex_value = {1'b0, d[3:0]};
			end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
				d = c - CH_UPPER_A + 8'd10;
				hex_value = {1'b0, d[3:0]};
			end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
				d = c - CH_LOWER_A + 8'd10;
				hex_value = {1'b0, d[3:0]};
			end else begin
				hex_value = 5'b10000;
			end
		end
	endfunction

endpackage

/* rtl/core/nmea_sentence_frame_parser.sv */
// top level of the nmea sentence frame parser
// depends on nmea_pkg, nmea_front, nmea_queue and nmea_back
`timescale 1ns / 1ps

// usage:
//  byte channel (byte_valid / byte_stall / byte_item) carries one sentence
//  character per request, end_of_buffer set on the last one.
//  result channel (result_valid / result_stall / result_item) gives, for a
//  good sentence, one field descriptor per recorded field and then a status
//  item with last_result set; a failing sentence gives only the status item.
//  throughput: one byte per cycle while a sentence is scanned; the front end
//  classifies each byte and a two-entry queue feeds the back end.
//  at the end of a sentence the back end walks the field table, a table read
//  and an output load per descriptor, then loads the status; the queue
//  absorbs two further bytes and then byte_stall stays high until the back
//  end resumes the scan once the status is loaded.
//  after the final byte leaves the queue, behind any bytes queued ahead of
//  it, the first descriptor passes a table read and an output load, and a
//  failing status goes straight into the output register.
//  when the receiver stalls, the output register holds its request and the
//  back end waits at its next descriptor or status load, then the queue fills and byte_stall goes high.
//  reset (arst_n low) clears position, checksum, flags, queue and output
//  valid; the field table is not cleared, only entries written in the
//  current sentence are read.

module nmea_sentence_frame_parser import nmea_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_stall,
	input  in_item_t  byte_item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result_item
);

	logic     push;
	q_entry_t push_data;
	logic     q_full;
	logic     q_empty;
	logic     q_pop;
	q_entry_t q_data;

	assign byte_stall = q_full;

	nmea_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_item (byte_item),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	nmea_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_data(push_data),
		.full   (q_full),
		.rd_en  (q_pop),
		.rd_data(q_data),
		.empty  (q_empty)
	);

	nmea_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_data      (q_data),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item (result_item)
	);

endmodule

/* rtl/core/nmea_front.sv */
// front end: accepts sentence bytes, tracks position and the star scan,
// and tags each byte with its kind; depends on nmea_pkg
`timescale 1ns / 1ps

module nmea_front import nmea_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_valid,
	input  in_item_t byte_item,
	input  logic     q_full,
	output logic     push,
	output q_entry_t push_data
);

	logic [7:0] pos_q;
	logic       star_found_q;
	logic       scan_stopped_q;
	logic [7:0] star_pos_q;

	logic       star_found_n;
	logic       scan_stopped_n;
	logic [7:0] star_pos_n;
	byte_kind_t kind;
	logic [7:0] b;

	assign push = byte_valid && !q_full;
	assign b    = byte_item.data_byte;

	always_comb begin
		kind           = K_NONE;
		star_found_n   = star_found_q;
		scan_stopped_n = scan_stopped_q;
		star_pos_n     = star_pos_q;
		if (pos_q < 8'(MAX_SENTENCE_LEN)) begin
			if (pos_q == 8'd0) begin
				kind = K_LEAD;
			end else if (!star_found_q && !scan_stopped_q) begin
				if (b == CH_STAR) begin
					kind         = K_STAR;
					star_found_n = 1'b1;
					star_pos_n   = pos_q;
				end else if (b == CH_CR || b == CH_LF) begin
					scan_stopped_n = 1'b1;
				end else begin
					kind = K_DATA;
				end
			end else if (star_found_q) begin
				if ({1'b0, pos_q} == {1'b0, star_pos_q} + 9'd1) begin
					kind = K_DIGIT_HI;
				end else if ({1'b0, pos_q} == {1'b0, star_pos_q} + 9'd2) begin
					kind = K_DIGIT_LO;
				end
			end
		end
	end

	always_comb begin
		push_data.data_byte  = b;
		push_data.pos        = pos_q;
		push_data.kind       = kind;
		push_data.last       = byte_item.end_of_buffer;
		push_data.star_found = star_found_n;
		push_data.star_pos   = star_pos_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= 8'd0;
			star_found_q   <= 1'b0;
			scan_stopped_q <= 1'b0;
			star_pos_q     <= 8'd0;
		end else if (push) begin
			if (byte_item.end_of_buffer) begin
				pos_q          <= 8'd0;
				star_found_q   <= 1'b0;
				scan_stopped_q <= 1'b0;
				star_pos_q     <= 8'd0;
			end else begin
				// position saturates so very long sentences stay flagged
				if (pos_q != 8'hFF) begin
					pos_q <= pos_q + 8'd1;
				end
				star_found_q   <= star_found_n;
				scan_stopped_q <= scan_stopped_n;
				star_pos_q     <= star_pos_n;
			end
		end
	end

	a_star_in_bound: assert property (@(posedge clk) disable iff (!arst_n)
		star_found_q |-> (star_pos_q < 8'(MAX_SENTENCE_LEN)) && (star_pos_q != 8'd0))
		else $error("star position outside scanned range");

	a_star_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(star_found_q && !(push && byte_item.end_of_buffer)) |=> star_found_q)
		else $error("star flag dropped inside a sentence");

	a_star_blocks_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(push && star_found_q) |-> (kind != K_STAR && kind != K_DATA))
		else $error("scan continued past the star");

endmodule

/* rtl/core/nmea_queue.sv */
// short register queue between front and back end
// depends on nmea_pkg for the entry type and depth
`timescale 1ns / 1ps

module nmea_queue import nmea_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_en,
	input  q_entry_t wr_data,
	output logic     full,
	input  logic     rd_en,
	output q_entry_t rd_data,
	output logic     empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	q_entry_t             slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = slots_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		begin
			if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
				next_ptr = '0;
			end else begin
				next_ptr = p + PTR_W'(1);
			end
		end
	endfunction

	always_ff @(posedge clk) begin
		if (wr_en && !full) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en && !full) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (rd_en && !empty) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({wr_en && !full, rd_en && !empty})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !rd_en) |=> full)
		else $error("queue lost an entry while full");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(empty || full) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers out of step with count");

endmodule

/* rtl/core/nmea_back.sv */
// back end: checksum, field table, address capture and result sequencing
// depends on nmea_pkg; holds the field table memory
`timescale 1ns / 1ps

module nmea_back import nmea_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  q_entry_t  q_data,
	input  logic      q_empty,
	output logic      q_pop,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result_item
);

	typedef enum logic [3:0] {
		S_RUN  = 4'b0001,
		S_READ = 4'b0010,
		S_LOAD = 4'b0100,
		S_STAT = 4'b1000
	} seq_state_t;

	seq_state_t  state_q;
	logic        lead_ok_q;
	logic [7:0]  xor_q;
	logic [7:0]  digit_hi_q;
	logic [7:0]  digit_lo_q;
	logic [5:0]  fcnt_q;
	logic [7:0]  cur_start_q;
	logic [15:0] talker_q;
	logic [23:0] type_q;
	err_code_t   err_q;
	logic [4:0]  idx_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic [6:0]  start_mem [TABLE_DEPTH];
	logic [6:0]  length_mem [TABLE_DEPTH];
	logic [6:0]  rd_start_q;
	logic [6:0]  rd_length_q;

	logic        lead_ok_n;
	logic [7:0]  xor_n;
	logic [7:0]  digit_hi_n;
	logic [7:0]  digit_lo_n;
	logic [5:0]  fcnt_n;
	logic [7:0]  cur_start_n;
	logic [15:0] talker_n;
	logic [23:0] type_n;
	logic        mem_we;
	logic [4:0]  mem_waddr;
	logic [6:0]  mem_wstart;
	logic [6:0]  mem_wlength;
	logic [7:0]  span;
	err_code_t   err_n;
	logic [8:0]  len;
	logic [4:0]  hv;
	logic [4:0]  lv;
	logic        out_free;
	logic        load_desc;
	logic        load_status;
	logic [7:0]  b;
	logic [7:0]  p;
	out_item_t   out_n;

	assign q_pop    = (state_q == S_RUN) && !q_empty;
	assign out_free = !out_valid_q || !result_stall;
	assign b        = q_data.data_byte;
	assign p        = q_data.pos;
	assign span     = p - cur_start_q;

	// per-byte update of the sentence state
	always_comb begin
		lead_ok_n   = lead_ok_q;
		xor_n       = xor_q;
		digit_hi_n  = digit_hi_q;
		digit_lo_n  = digit_lo_q;
		fcnt_n      = fcnt_q;
		cur_start_n = cur_start_q;
		talker_n    = talker_q;
		type_n      = type_q;
		mem_we      = 1'b0;
		mem_waddr   = fcnt_q[4:0];
		mem_wstart  = cur_start_q[6:0];
		mem_wlength = span[6:0];
		case (q_data.kind)
			K_LEAD: begin
				lead_ok_n = (b == CH_DOLLAR) || (b == CH_BANG);
			end
			K_STAR, K_DATA: begin
				if (q_data.kind == K_DATA) begin
					xor_n = xor_q ^ b;
				end
				if (q_data.kind == K_STAR || b == CH_COMMA) begin
					// close the current field; past the cap it only delimits
					if (fcnt_q < 6'(FIELD_CAP)) begin
						mem_we = 1'b1;
						fcnt_n = fcnt_q + 6'd1;
					end
					cur_start_n = p + 8'd1;
				end else if (fcnt_q == 6'd0) begin
					case (p)
						8'd1:    talker_n[15:8] = talker_q[15:8] | b;
						8'd2:    talker_n[7:0]  = talker_q[7:0] | b;
						8'd3:    type_n[23:16]  = type_q[23:16] | b;
						8'd4:    type_n[15:8]   = type_q[15:8] | b;
						8'd5:    type_n[7:0]    = type_q[7:0] | b;
						default: type_n         = type_q;
					endcase
				end
			end
			K_DIGIT_HI: digit_hi_n = b;
			K_DIGIT_LO: digit_lo_n = b;
			default: begin
				lead_ok_n = lead_ok_q;
			end
		endcase
	end

	// sentence verdict, valid on the final byte
	always_comb begin
		len = {1'b0, p} + 9'd1;
		hv  = hex_value(digit_hi_n);
		lv  = hex_value(digit_lo_n);
		if (len > 9'(MAX_SENTENCE_LEN)) begin
			err_n = ERR_LONG;
		end else if (len < 9'd4) begin
			err_n = ERR_SHORT;
		end else if (!lead_ok_n) begin
			err_n = ERR_LEAD;
		end else if (!q_data.star_found) begin
			err_n = ERR_NO_STAR;
		end else if ({1'b0, q_data.star_pos} + 9'd2 >= len) begin
			err_n = ERR_DIGITS;
		end else if (hv[4] || lv[4]) begin
			err_n = ERR_HEX;
		end else if ({hv[3:0], lv[3:0]} != xor_n) begin
			err_n = ERR_MISMATCH;
		end else begin
			err_n = ERR_OK;
		end
	end

	assign load_desc   = (state_q == S_LOAD) && out_free;
	assign load_status = (state_q == S_STAT) && out_free;

	// next result request, descriptor or status
	always_comb begin
		out_n = '0;
		if (state_q == S_STAT) begin
			out_n.is_status   = 1'b1;
			out_n.error_code  = err_q;
			out_n.last_result = 1'b1;
			if (err_q == ERR_OK) begin
				out_n.field_total  = fcnt_q;
				out_n.talker_chars = talker_q;
				out_n.type_chars   = type_q;
			end
		end else begin
			out_n.field_index  = idx_q;
			out_n.field_start  = rd_start_q;
			out_n.field_length = rd_length_q;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && mem_we) begin
			start_mem[mem_waddr]  <= mem_wstart;
			length_mem[mem_waddr] <= mem_wlength;
		end
		if (state_q == S_READ) begin
			rd_start_q  <= start_mem[idx_q];
			rd_length_q <= length_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (load_desc || load_status) begin
			out_q <= out_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RUN;
			lead_ok_q   <= 1'b0;
			xor_q       <= 8'd0;
			digit_hi_q  <= 8'd0;
			digit_lo_q  <= 8'd0;
			fcnt_q      <= 6'd0;
			cur_start_q <= 8'd1;
			talker_q    <= 16'd0;
			type_q      <= 24'd0;
			err_q       <= ERR_OK;
			idx_q       <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_desc || load_status) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_RUN: begin
					if (q_pop) begin
						lead_ok_q   <= lead_ok_n;
						xor_q       <= xor_n;
						digit_hi_q  <= digit_hi_n;
						digit_lo_q  <= digit_lo_n;
						fcnt_q      <= fcnt_n;
						cur_start_q <= cur_start_n;
						talker_q    <= talker_n;
						type_q      <= type_n;
						if (q_data.last) begin
							err_q <= err_n;
							idx_q <= 5'd0;
							if (err_n == ERR_OK && fcnt_n != 6'd0) begin
								state_q <= S_READ;
							end else begin
								state_q <= S_STAT;
							end
						end
					end
				end
				S_READ: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (load_desc) begin
						if ({1'b0, idx_q} + 6'd1 < fcnt_q) begin
							idx_q   <= idx_q + 5'd1;
							state_q <= S_READ;
						end else begin
							state_q <= S_STAT;
						end
					end
				end
				S_STAT: begin
					if (load_status) begin
						// sentence done, back to the reset picture
						lead_ok_q   <= 1'b0;
						xor_q       <= 8'd0;
						digit_hi_q  <= 8'd0;
						digit_lo_q  <= 8'd0;
						fcnt_q      <= 6'd0;
						cur_start_q <= 8'd1;
						talker_q    <= 16'd0;
						type_q      <= 24'd0;
						err_q       <= ERR_OK;
						idx_q       <= 5'd0;
						state_q     <= S_RUN;
					end
				end
				default: begin
					state_q <= S_RUN;
				end
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign result_item  = out_q;

	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= 6'(FIELD_CAP))
		else $error("field count beyond cap");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> ({1'b0, idx_q} < fcnt_q && err_q == ERR_OK))
		else $error("table read past recorded fields");

	a_status_returns: assert property (@(posedge clk) disable iff (!arst_n)
		load_status |=> (state_q == S_RUN && fcnt_q == 6'd0 && result_item.is_status))
		else $error("status did not close the sentence");

	a_no_pop_while_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_RUN) |-> !q_pop)
		else $error("queue popped during emission");

endmodule
